>>> rtl/aacc_pkg.sv
// shared types, constants and the smoothstep table for the circle coverage block
// no dependencies; every other file refers to this package by scoped names

package aacc_pkg;

    // field and datapath widths
    localparam int COORD_W    = 16;
    localparam int DIM_W      = 15;
    localparam int ALPHA_W    = 8;
    localparam int R_W        = 14;
    localparam int SQ_W       = 28;
    localparam int DSQ_W      = 29;
    localparam int MAG_W      = 15;
    localparam int NUM_W      = 23;
    localparam int Q_W        = 9;
    localparam int DIV_STAGES = 9;
    localparam int COV_W      = 9;
    localparam int M_W        = 10;

    // arithmetic constants
    localparam int AA_HALF    = 192;
    localparam int ALPHA_FULL = 255;
    localparam int SD_SHIFT   = 7;
    localparam int RECIP3     = 683;
    localparam int RECIP3_SH  = 11;
    localparam int SM_DIV     = ALPHA_FULL * ALPHA_FULL;
    localparam int SM_ROUND   = SM_DIV / 2;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    // pixel class after geometry checks
    typedef enum logic [1:0] {
        CLS_CLEAR  = 2'd0,
        CLS_FULL   = 2'd1,
        CLS_FRINGE = 2'd2
    } cls_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic [ALPHA_W-1:0]        in_alpha;
    } pixel_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] out_alpha;
        logic               color_cleared;
    } result_t;

    // circle geometry derived from the rectangle registers
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W:0]   right_end;
        logic signed [COORD_W:0]   bottom_end;
        logic signed [COORD_W:0]   cx;
        logic signed [COORD_W:0]   cy;
        logic [R_W-1:0]            r;
        logic [R_W-2:0]            r_half;
        logic [SQ_W-1:0]           rsq;
        logic [SQ_W-1:0]           inner;
        logic [SQ_W-1:0]           outer;
    } geom_t;

    // queue entry: classified pixel plus divider numerator
    typedef struct packed {
        cls_t               cls;
        logic               neg;
        logic [NUM_W-1:0]   num;
        logic [ALPHA_W-1:0] alpha;
    } qent_t;

    typedef logic [ALPHA_W-1:0] sm_tab_t [0:255];

    // smoothstep of t in 0..255, scaled to 0..255
    function automatic sm_tab_t build_sm_tab();
        sm_tab_t tab;
        int      t_sq;
        int      sm;
        for (int i = 0; i < 256; i++)
        begin
            t_sq = i * i;
            sm = (3 * t_sq * ALPHA_FULL - 2 * t_sq * i + SM_ROUND) / SM_DIV;
            if (sm < 0)
            begin
                sm = 0;
            end
            if (sm > ALPHA_FULL)
            begin
                sm = ALPHA_FULL;
            end
            tab[i] = ALPHA_W'(sm);
        end
        return tab;
    endfunction

    localparam sm_tab_t SM_TAB = build_sm_tab();

endpackage

>>> rtl/aacc_geom.sv
// rectangle configuration registers and the registered circle geometry
// depends on aacc_pkg

module aacc_geom (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [aacc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aacc_pkg::COORD_W-1:0]      cfg_data,
    output aacc_pkg::geom_t                   geom
);

    logic signed [aacc_pkg::COORD_W-1:0] left_reg;
    logic signed [aacc_pkg::COORD_W-1:0] top_reg;
    logic [aacc_pkg::DIM_W-1:0]          width_reg;
    logic [aacc_pkg::DIM_W-1:0]          height_reg;
    logic [aacc_pkg::DIM_W-1:0]          min_dim;
    logic [aacc_pkg::R_W-1:0]            half_dim;
    logic [aacc_pkg::R_W-1:0]            r_val;
    logic [aacc_pkg::R_W-1:0]            r_m1;
    logic [aacc_pkg::R_W-1:0]            r_p1;
    aacc_pkg::geom_t                     geom_reg;
    aacc_pkg::geom_t                     geom_next;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aacc_pkg::REG_LEFT:   left_reg   <= cfg_data;
                aacc_pkg::REG_TOP:    top_reg    <= cfg_data;
                aacc_pkg::REG_WIDTH:  width_reg  <= cfg_data[aacc_pkg::DIM_W-1:0];
                aacc_pkg::REG_HEIGHT: height_reg <= cfg_data[aacc_pkg::DIM_W-1:0];
                default:              left_reg   <= left_reg;
            endcase
        end
    end

    // radius is half the smaller side minus one, clamped at zero
    always_comb
    begin
        min_dim  = (width_reg < height_reg) ? width_reg : height_reg;
        half_dim = min_dim[aacc_pkg::DIM_W-1:1];
        r_val    = (half_dim == '0) ? '0 : half_dim - 1'b1;
        r_m1     = r_val - 1'b1;
        r_p1     = r_val + 1'b1;
    end

    // derived geometry
    always_comb
    begin
        geom_next.left       = left_reg;
        geom_next.top        = top_reg;
        geom_next.right_end  = 17'(left_reg) + $signed({2'b00, width_reg});
        geom_next.bottom_end = 17'(top_reg) + $signed({2'b00, height_reg});
        geom_next.cx         = 17'(left_reg) + $signed({3'b000, width_reg[aacc_pkg::DIM_W-1:1]});
        geom_next.cy         = 17'(top_reg) + $signed({3'b000, height_reg[aacc_pkg::DIM_W-1:1]});
        geom_next.r          = r_val;
        geom_next.r_half     = r_val[aacc_pkg::R_W-1:1];
        geom_next.rsq        = aacc_pkg::SQ_W'(r_val) * aacc_pkg::SQ_W'(r_val);
        geom_next.inner      = aacc_pkg::SQ_W'(r_m1) * aacc_pkg::SQ_W'(r_m1);
        geom_next.outer      = aacc_pkg::SQ_W'(r_p1) * aacc_pkg::SQ_W'(r_p1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= '0;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

>>> rtl/aacc_front.sv
// front pipeline: takes pixels, checks the rectangle and circle extent, squares
// the offsets and classifies each pixel; depends on aacc_pkg

module aacc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    input  aacc_pkg::pixel_t    pixel,
    output logic                pixel_stall,
    input  logic                cfg_busy,
    input  aacc_pkg::geom_t     geom,
    input  logic                fifo_full,
    output logic                push,
    output aacc_pkg::qent_t     push_data
);

    typedef struct packed {
        aacc_pkg::cls_t                  cls;
        logic [aacc_pkg::R_W-1:0]        dx;
        logic [aacc_pkg::R_W-1:0]        dy;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } p2_t;

    typedef struct packed {
        aacc_pkg::cls_t                  cls;
        logic [aacc_pkg::SQ_W-1:0]       dxsq;
        logic [aacc_pkg::SQ_W-1:0]       dysq;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } p3_t;

    typedef struct packed {
        aacc_pkg::cls_t                  cls;
        logic [aacc_pkg::DSQ_W-1:0]      dsq;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } p4_t;

    logic                                adv;
    logic                                accept;
    logic [3:0]                          valid_reg;
    aacc_pkg::pixel_t                    p1_reg;
    p2_t                                 p2_reg;
    p2_t                                 p2_next;
    p3_t                                 p3_reg;
    p3_t                                 p3_next;
    p4_t                                 p4_reg;
    p4_t                                 p4_next;
    logic signed [aacc_pkg::COORD_W:0]   x1;
    logic signed [aacc_pkg::COORD_W:0]   y1;
    logic signed [aacc_pkg::COORD_W+1:0] ddx;
    logic signed [aacc_pkg::COORD_W+1:0] ddy;
    logic [aacc_pkg::COORD_W:0]          adx;
    logic [aacc_pkg::COORD_W:0]          ady;
    logic                                in_rect;
    logic                                near;
    logic [aacc_pkg::DSQ_W:0]            diff;
    logic [aacc_pkg::DSQ_W:0]            mag;

    // whole front moves together; it holds only when its last stage has a pixel and the queue is full
    assign adv         = !(valid_reg[3] && fifo_full);
    assign pixel_stall = !adv || cfg_busy;
    assign accept      = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[2:0], accept};
        end
    end

    // rectangle and extent checks, absolute offsets
    always_comb
    begin
        x1      = 17'(p1_reg.pixel_x);
        y1      = 17'(p1_reg.pixel_y);
        in_rect = (x1 >= 17'(geom.left)) && (x1 < geom.right_end)
               && (y1 >= 17'(geom.top)) && (y1 < geom.bottom_end);
        ddx     = 18'(x1) - 18'(geom.cx);
        ddy     = 18'(y1) - 18'(geom.cy);
        adx     = ddx[aacc_pkg::COORD_W+1] ? 17'(-ddx) : 17'(ddx);
        ady     = ddy[aacc_pkg::COORD_W+1] ? 17'(-ddy) : 17'(ddy);
        near    = (adx <= 17'(geom.r)) && (ady <= 17'(geom.r));
        if (!(in_rect && near))
        begin
            p2_next.cls = aacc_pkg::CLS_CLEAR;
        end
        else if (geom.r == '0)
        begin
            p2_next.cls = aacc_pkg::CLS_FULL;
        end
        else
        begin
            p2_next.cls = aacc_pkg::CLS_FRINGE;
        end
        p2_next.dx    = adx[aacc_pkg::R_W-1:0];
        p2_next.dy    = ady[aacc_pkg::R_W-1:0];
        p2_next.alpha = p1_reg.in_alpha;
    end

    // squares of the offsets
    always_comb
    begin
        p3_next.cls   = p2_reg.cls;
        p3_next.dxsq  = aacc_pkg::SQ_W'(p2_reg.dx) * aacc_pkg::SQ_W'(p2_reg.dx);
        p3_next.dysq  = aacc_pkg::SQ_W'(p2_reg.dy) * aacc_pkg::SQ_W'(p2_reg.dy);
        p3_next.alpha = p2_reg.alpha;
    end

    // squared distance
    always_comb
    begin
        p4_next.cls   = p3_reg.cls;
        p4_next.dsq   = aacc_pkg::DSQ_W'(p3_reg.dxsq) + aacc_pkg::DSQ_W'(p3_reg.dysq);
        p4_next.alpha = p3_reg.alpha;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= pixel;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
        end
    end

    // ring classification and divider numerator
    always_comb
    begin
        diff = (aacc_pkg::DSQ_W+1)'(p4_reg.dsq) - (aacc_pkg::DSQ_W+1)'(geom.rsq);
        mag  = diff[aacc_pkg::DSQ_W] ? -diff : diff;
        push_data.cls = p4_reg.cls;
        if (p4_reg.cls == aacc_pkg::CLS_FRINGE)
        begin
            if (p4_reg.dsq <= aacc_pkg::DSQ_W'(geom.inner))
            begin
                push_data.cls = aacc_pkg::CLS_FULL;
            end
            else if (p4_reg.dsq >= aacc_pkg::DSQ_W'(geom.outer))
            begin
                push_data.cls = aacc_pkg::CLS_CLEAR;
            end
        end
        push_data.neg   = diff[aacc_pkg::DSQ_W];
        push_data.num   = (aacc_pkg::NUM_W'(mag[aacc_pkg::MAG_W-1:0]) << aacc_pkg::SD_SHIFT)
                        + aacc_pkg::NUM_W'(geom.r_half);
        push_data.alpha = p4_reg.alpha;
    end

    assign push = valid_reg[3] && !fifo_full;

endmodule

>>> rtl/aacc_fifo.sv
// short queue of classified pixels between the front and back pipelines
// depends on aacc_pkg

module aacc_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  aacc_pkg::qent_t    push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output aacc_pkg::qent_t    head
);

    aacc_pkg::qent_t                 mem_reg [0:aacc_pkg::FIFO_DEPTH-1];
    logic [aacc_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [aacc_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [aacc_pkg::FIFO_AW:0]      count_reg;
    logic [aacc_pkg::FIFO_AW:0]      count_next;

    assign full       = (count_reg == (aacc_pkg::FIFO_AW+1)'(aacc_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/aacc_back.sv
// back pipeline: one-bit-per-stage divider for the signed edge distance, smoothstep,
// alpha mix and the output register; depends on aacc_pkg

module aacc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  aacc_pkg::geom_t     geom,
    input  logic                head_valid,
    input  aacc_pkg::qent_t     head,
    output logic                pop,
    output logic                result_valid,
    output aacc_pkg::result_t   result,
    input  logic                result_stall
);

    typedef struct packed {
        aacc_pkg::cls_t                  cls;
        logic                            neg;
        logic [aacc_pkg::NUM_W-1:0]      rem;
        logic [aacc_pkg::Q_W-1:0]        q;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } dv_t;

    typedef struct packed {
        aacc_pkg::cls_t                  cls;
        logic [aacc_pkg::M_W-1:0]        m;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } s1_t;

    typedef struct packed {
        aacc_pkg::cls_t                  cls;
        logic [aacc_pkg::ALPHA_W-1:0]    t;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } s2_t;

    typedef struct packed {
        logic                            cleared;
        logic [aacc_pkg::ALPHA_W-1:0]    c;
        logic [aacc_pkg::ALPHA_W-1:0]    alpha;
    } s3_t;

    typedef struct packed {
        logic                            cleared;
        logic                            byp;
        logic [aacc_pkg::ALPHA_W-1:0]    bv;
        logic [2*aacc_pkg::ALPHA_W-1:0]  prod;
    } s4_t;

    localparam logic [aacc_pkg::ALPHA_W-1:0] FULL8 = aacc_pkg::ALPHA_W'(aacc_pkg::ALPHA_FULL);
    localparam logic [aacc_pkg::Q_W-1:0]     HALF9 = aacc_pkg::Q_W'(aacc_pkg::AA_HALF);

    logic                                adv;
    logic [aacc_pkg::DIV_STAGES:0]       dv_valid_reg;
    dv_t                                 dv_reg [0:aacc_pkg::DIV_STAGES];
    dv_t                                 dv_next [0:aacc_pkg::DIV_STAGES];
    logic [3:0]                          s_valid_reg;
    s1_t                                 s1_reg;
    s1_t                                 s1_next;
    s2_t                                 s2_reg;
    s2_t                                 s2_next;
    s3_t                                 s3_reg;
    s3_t                                 s3_next;
    s4_t                                 s4_reg;
    s4_t                                 s4_next;
    aacc_pkg::result_t                   result_reg;
    aacc_pkg::result_t                   result_next;
    logic                                result_valid_reg;
    logic [aacc_pkg::Q_W-1:0]            q_fin;
    logic [aacc_pkg::COV_W-1:0]          cov;
    logic [16:0]                         cov_scaled;
    logic [19:0]                         t_prod;
    logic [2*aacc_pkg::ALPHA_W:0]        div255;

    // back moves as one; it holds only while a result waits to be taken
    assign adv          = !(result_valid_reg && result_stall);
    assign pop          = adv && head_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // divider input from the queue head
    always_comb
    begin
        dv_next[0].cls   = head.cls;
        dv_next[0].neg   = head.neg;
        dv_next[0].rem   = head.num;
        dv_next[0].q     = '0;
        dv_next[0].alpha = head.alpha;
    end

    // restoring divide by the radius, most significant quotient bit first
    for (genvar k = 0; k < aacc_pkg::DIV_STAGES; k++)
    begin : g_div
        localparam int SH = aacc_pkg::DIV_STAGES - 1 - k;
        logic [aacc_pkg::NUM_W-1:0] sub;
        logic                       ge;

        always_comb
        begin
            sub              = aacc_pkg::NUM_W'(geom.r) << SH;
            ge               = (dv_reg[k].rem >= sub);
            dv_next[k+1]     = dv_reg[k];
            dv_next[k+1].rem = ge ? dv_reg[k].rem - sub : dv_reg[k].rem;
            dv_next[k+1].q[SH] = ge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= aacc_pkg::DIV_STAGES; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
        end
    end

    // saturation and smoothstep argument scaled to t
    always_comb
    begin
        q_fin         = dv_reg[aacc_pkg::DIV_STAGES].q;
        cov           = dv_reg[aacc_pkg::DIV_STAGES].neg ? HALF9 + q_fin : HALF9 - q_fin;
        cov_scaled    = 17'(cov) * 17'(aacc_pkg::ALPHA_FULL) + 17'(aacc_pkg::AA_HALF);
        s1_next.cls   = dv_reg[aacc_pkg::DIV_STAGES].cls;
        if ((dv_reg[aacc_pkg::DIV_STAGES].cls == aacc_pkg::CLS_FRINGE) && (q_fin >= HALF9))
        begin
            s1_next.cls = dv_reg[aacc_pkg::DIV_STAGES].neg ? aacc_pkg::CLS_FULL
                                                           : aacc_pkg::CLS_CLEAR;
        end
        s1_next.m     = cov_scaled[16:7];
        s1_next.alpha = dv_reg[aacc_pkg::DIV_STAGES].alpha;
    end

    // divide by three through the reciprocal
    always_comb
    begin
        t_prod        = 20'(s1_reg.m) * 20'(aacc_pkg::RECIP3);
        s2_next.cls   = s1_reg.cls;
        s2_next.t     = t_prod[aacc_pkg::RECIP3_SH +: aacc_pkg::ALPHA_W];
        s2_next.alpha = s1_reg.alpha;
    end

    // coverage value
    always_comb
    begin
        case (s2_reg.cls)
            aacc_pkg::CLS_FULL:   s3_next.c = FULL8;
            aacc_pkg::CLS_FRINGE: s3_next.c = aacc_pkg::SM_TAB[s2_reg.t];
            default:              s3_next.c = '0;
        endcase
        s3_next.cleared = (s3_next.c == '0);
        s3_next.alpha   = s2_reg.alpha;
    end

    // alpha mix product, opaque operands pass the other one through
    always_comb
    begin
        s4_next.cleared = s3_reg.cleared;
        s4_next.byp     = (s3_reg.c == FULL8) || (s3_reg.alpha == FULL8);
        s4_next.bv      = (s3_reg.c == FULL8) ? s3_reg.alpha : s3_reg.c;
        s4_next.prod    = (2*aacc_pkg::ALPHA_W)'(s3_reg.c)
                        * (2*aacc_pkg::ALPHA_W)'(s3_reg.alpha);
    end

    // exact divide by 255 for products of two 8-bit values
    always_comb
    begin
        div255 = (2*aacc_pkg::ALPHA_W+1)'(s4_reg.prod) + 1'b1
               + (2*aacc_pkg::ALPHA_W+1)'(s4_reg.prod[2*aacc_pkg::ALPHA_W-1:aacc_pkg::ALPHA_W]);
        result_next.color_cleared = s4_reg.cleared;
        if (s4_reg.cleared)
        begin
            result_next.out_alpha = '0;
        end
        else if (s4_reg.byp)
        begin
            result_next.out_alpha = s4_reg.bv;
        end
        else
        begin
            result_next.out_alpha = div255[2*aacc_pkg::ALPHA_W-1:aacc_pkg::ALPHA_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s4_reg     <= s4_next;
            result_reg <= result_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg     <= '0;
            s_valid_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg     <= {dv_valid_reg[aacc_pkg::DIV_STAGES-1:0], head_valid};
            s_valid_reg      <= {s_valid_reg[2:0], dv_valid_reg[aacc_pkg::DIV_STAGES]};
            result_valid_reg <= s_valid_reg[3];
        end
    end

endmodule

>>> rtl/aa_circle_pixel_coverage_core.sv
// top level of the antialiased circle pixel coverage block
// depends on aacc_pkg, aacc_geom, aacc_front, aacc_fifo, aacc_back

// Takes one pixel per clock while pixel_stall is low and returns one result per
// pixel, in order. The circle comes from the rectangle registers: center at its
// middle, radius half the smaller side less one. Pixels outside get alpha 0 and
// color_cleared set; pixels within a pixel of the edge get smoothstep coverage
// mixed with their alpha. Sustained rate is one pixel per cycle when no result
// waits and no register write is made; the path includes the nine divider stages
// that each produce one quotient bit of the edge distance. With nothing waiting,
// a pixel passes the four front registers, the queue, ten divider registers,
// four coverage and mix stages and the output register before result_valid
// rises. While a result waits the whole back pipeline holds; the four front
// stages and the four-entry queue keep taking pixels until they fill.
// Register writes are taken at any cycle (cfg_ready is always high), should
// only be made while no pixel is in flight, and hold off pixels for the cycle
// of the write.

module aa_circle_pixel_coverage_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    input  aacc_pkg::pixel_t                  pixel,
    output logic                              pixel_stall,
    output logic                              result_valid,
    output aacc_pkg::result_t                 result,
    input  logic                              result_stall,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [aacc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aacc_pkg::COORD_W-1:0]      cfg_data
);

    aacc_pkg::geom_t geom;
    aacc_pkg::qent_t push_data;
    aacc_pkg::qent_t head;
    logic            push;
    logic            pop;
    logic            fifo_full;
    logic            head_valid;

    assign cfg_ready = 1'b1;

    // configuration and circle geometry
    aacc_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // classification pipeline
    aacc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .pixel_stall (pixel_stall),
        .cfg_busy    (cfg_valid),
        .geom        (geom),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_data   (push_data)
    );

    // decoupling queue
    aacc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // distance, coverage and mix pipeline
    aacc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule
